>>> hdl/fm_index_occurrence_counter_core_assert.svh
`ifndef FM_INDEX_OCCURRENCE_COUNTER_CORE_ASSERT_SVH
`define FM_INDEX_OCCURRENCE_COUNTER_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define FMOCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fmocc check failed");

// Check that cons holds in the cycle after ante.
`define FMOCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fmocc check failed");

`endif

>>> hdl/fmocc_pkg.sv
package fmocc_pkg;

	localparam int NumLetters  = 20;
	localparam int CodeW       = 5;
	localparam int PosW        = 16;
	localparam int CountW      = 17;
	localparam int QueueDepth  = 4;
	localparam int QueuePtrW   = $clog2(QueueDepth);
	localparam int QueueCountW = $clog2(QueueDepth + 1);

	localparam logic [CodeW-1:0]  CodeDollar  = 5'd20;
	localparam logic [CodeW-1:0]  CodeInvalid = 5'd21;
	localparam logic [CodeW-1:0]  LastLetter  = 5'd19;
	localparam logic [7:0]        DollarChar  = 8'h24;
	localparam logic [CountW-1:0] CountCap    = 17'd65536;

	// A C D E F G H I K L M N P Q R S T V W Y
	localparam logic [7:0] LetterChar [NumLetters] = '{
		8'h41, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4B, 8'h4C,
		8'h4D, 8'h4E, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h56, 8'h57, 8'h59
	};

	typedef struct packed {
		logic [CodeW-1:0] code;
		logic             last;
		logic [PosW-1:0]  pos;
	} entry_t;

	typedef enum logic {
		ST_OCC,
		ST_BURST
	} back_state_t;

	function automatic logic [CodeW-1:0] map_symbol(input logic [7:0] sym);
		logic [CodeW-1:0] code;
		code = (sym == DollarChar) ? CodeDollar : CodeInvalid;
		for (int i = 0; i < NumLetters; i++) begin
			if (sym == LetterChar[i]) begin
				code = CodeW'(i);
			end
		end
		return code;
	endfunction

endpackage

>>> hdl/fmocc_front.sv
module fmocc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sym_valid,
	output logic                sym_ready,
	input  logic [7:0]          symbol,
	input  logic                last,
	input  logic                q_full,
	output logic                q_push,
	output fmocc_pkg::entry_t   q_wdata
);

	logic [fmocc_pkg::PosW-1:0] pos_q;

	assign sym_ready = !q_full;
	assign q_push    = sym_valid && sym_ready;

	always_comb begin
		q_wdata.code = fmocc_pkg::map_symbol(symbol);
		q_wdata.last = last;
		q_wdata.pos  = pos_q;
	end

	// Advance the position per word, restart after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (q_push) begin
			pos_q <= last ? '0 : pos_q + 1'b1;
		end
	end

endmodule

>>> hdl/fmocc_queue.sv
module fmocc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fmocc_pkg::entry_t   wdata,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output fmocc_pkg::entry_t   rdata
);

	fmocc_pkg::entry_t                  mem_q [fmocc_pkg::QueueDepth];
	logic [fmocc_pkg::QueuePtrW-1:0]    wr_ptr_q;
	logic [fmocc_pkg::QueuePtrW-1:0]    rd_ptr_q;
	logic [fmocc_pkg::QueueCountW-1:0]  fill_q;

	assign full      = (fill_q == fmocc_pkg::QueueCountW'(fmocc_pkg::QueueDepth));
	assign not_empty = (fill_q != '0);
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/fmocc_back.sv
`include "fm_index_occurrence_counter_core_assert.svh"

module fmocc_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	input  fmocc_pkg::entry_t                   q_rdata,
	output logic                                q_pop,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic                                kind,
	output logic [fmocc_pkg::CodeW-1:0]         letter,
	output logic [fmocc_pkg::PosW-1:0]          position,
	output logic [fmocc_pkg::CountW-1:0]        count,
	output logic                                invalid,
	output logic                                end_of_run
);

	fmocc_pkg::back_state_t             state_q, state_d;
	logic [fmocc_pkg::CountW-1:0]       counts_q [fmocc_pkg::NumLetters];
	logic [fmocc_pkg::CodeW-1:0]        j_q;
	logic [fmocc_pkg::CountW-1:0]       total_q;
	logic [fmocc_pkg::PosW-1:0]         burst_pos_q;

	logic                               res_valid_q;
	logic                               kind_q;
	logic [fmocc_pkg::CodeW-1:0]        letter_q;
	logic [fmocc_pkg::PosW-1:0]         position_q;
	logic [fmocc_pkg::CountW-1:0]       count_q;
	logic                               invalid_q;
	logic                               eor_q;

	logic                               out_adv;
	logic                               occ_go;
	logic                               burst_go;
	logic                               is_letter;
	logic [fmocc_pkg::CountW-1:0]       cnt_rd;
	logic [fmocc_pkg::CountW-1:0]       cnt_inc;
	logic [fmocc_pkg::CountW:0]         total_sum;
	logic [fmocc_pkg::CountW-1:0]       total_nxt;
	logic                               counts_zero;

	assign out_adv   = !res_valid_q || res_ready;
	assign is_letter = (q_rdata.code < fmocc_pkg::CodeW'(fmocc_pkg::NumLetters));
	assign cnt_rd    = is_letter ? counts_q[q_rdata.code] : '0;
	assign cnt_inc   = (cnt_rd < fmocc_pkg::CountCap) ? cnt_rd + 1'b1 : cnt_rd;
	assign total_sum = {1'b0, total_q} + {1'b0, counts_q[0]};
	assign total_nxt = (total_sum > {1'b0, fmocc_pkg::CountCap}) ?
		fmocc_pkg::CountCap : total_sum[fmocc_pkg::CountW-1:0];
	assign q_pop     = occ_go;

	always_comb begin
		counts_zero = 1'b1;
		for (int i = 0; i < fmocc_pkg::NumLetters; i++) begin
			if (counts_q[i] != '0) begin
				counts_zero = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fmocc_pkg::ST_OCC;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		occ_go   = 1'b0;
		burst_go = 1'b0;
		unique case (state_q)
			fmocc_pkg::ST_OCC: begin
				occ_go = q_valid && out_adv;
				if (occ_go && q_rdata.last) begin
					state_d = fmocc_pkg::ST_BURST;
				end
			end
			fmocc_pkg::ST_BURST: begin
				burst_go = out_adv;
				if (burst_go && (j_q == fmocc_pkg::LastLetter)) begin
					state_d = fmocc_pkg::ST_OCC;
				end
			end
			default: begin
				state_d = fmocc_pkg::ST_OCC;
			end
		endcase
	end

	// Count on occurrence words; during the C burst shift the counters
	// down so that the current letter always sits at the bottom, and
	// shift in zeros so that they are clear when the burst ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fmocc_pkg::NumLetters; i++) begin
				counts_q[i] <= '0;
			end
			j_q         <= '0;
			total_q     <= '0;
			burst_pos_q <= '0;
		end else if (occ_go) begin
			if (is_letter) begin
				counts_q[q_rdata.code] <= cnt_inc;
			end
			j_q         <= '0;
			total_q     <= '0;
			burst_pos_q <= q_rdata.pos;
		end else if (burst_go) begin
			for (int i = 0; i < fmocc_pkg::NumLetters - 1; i++) begin
				counts_q[i] <= counts_q[i+1];
			end
			counts_q[fmocc_pkg::NumLetters-1] <= '0;
			j_q     <= j_q + 1'b1;
			total_q <= total_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_adv) begin
			res_valid_q <= occ_go || burst_go;
		end
	end

	always_ff @(posedge clk) begin
		if (occ_go) begin
			kind_q     <= 1'b0;
			letter_q   <= q_rdata.code;
			position_q <= q_rdata.pos;
			count_q    <= is_letter ? cnt_inc : '0;
			invalid_q  <= (q_rdata.code == fmocc_pkg::CodeInvalid);
			eor_q      <= !q_rdata.last;
		end else if (burst_go) begin
			kind_q     <= 1'b1;
			letter_q   <= j_q;
			position_q <= burst_pos_q;
			count_q    <= total_q;
			invalid_q  <= 1'b0;
			eor_q      <= (j_q == fmocc_pkg::LastLetter);
		end
	end

	assign res_valid  = res_valid_q;
	assign kind       = kind_q;
	assign letter     = letter_q;
	assign position   = position_q;
	assign count      = count_q;
	assign invalid    = invalid_q;
	assign end_of_run = eor_q;

	`FMOCC_ASSERT_NOW(a_burst_index, clk, arst_n, state_q == fmocc_pkg::ST_BURST, j_q <= fmocc_pkg::LastLetter)
	`FMOCC_ASSERT_NOW(a_burst_end_letter, clk, arst_n, res_valid_q && kind_q && eor_q, letter_q == fmocc_pkg::LastLetter)
	`FMOCC_ASSERT_NOW(a_invalid_flag, clk, arst_n, res_valid_q && !kind_q, invalid_q == (letter_q == fmocc_pkg::CodeInvalid))
	`FMOCC_ASSERT_NOW(a_clear_after_burst, clk, arst_n, $fell(state_q == fmocc_pkg::ST_BURST), counts_zero)

endmodule

>>> hdl/fm_index_occurrence_counter_core.sv
// Channel | Handshake            | Words carried
// --------+----------------------+------------------------------------------------
// input   | sym_valid, sym_ready | symbol, last
// result  | res_valid, res_ready | kind, letter, position, count, invalid, end_of_run
//
// One occurrence word per input byte, one per cycle when nothing stalls.
// A byte marked last adds 20 C-value words from the counter bank, one per cycle
// while res_ready is high, so a transform of N bytes gives N + 20 result words.
// Reset (arst_n low) clears counters, position, queue and the result valid flag.
// A four-entry queue parts the input side from the counter bank; input stalls
// only when it is full, and the result register holds while res_ready is low.
module fm_index_occurrence_counter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sym_valid,
	output logic                                sym_ready,
	input  logic [7:0]                          symbol,
	input  logic                                last,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic                                kind,
	output logic [fmocc_pkg::CodeW-1:0]         letter,
	output logic [fmocc_pkg::PosW-1:0]          position,
	output logic [fmocc_pkg::CountW-1:0]        count,
	output logic                                invalid,
	output logic                                end_of_run
);

	// Front to queue: classified word with its position.
	logic               q_push;
	logic               q_full;
	fmocc_pkg::entry_t  q_wdata;

	// Queue to back: head word and its release.
	logic               q_pop;
	logic               q_not_empty;
	fmocc_pkg::entry_t  q_rdata;

	// Map each byte to its letter code and stamp its position.
	fmocc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.sym_ready (sym_ready),
		.symbol    (symbol),
		.last      (last),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	// Hold classified words while the back end is busy with a C burst
	// or stalled by the result side.
	fmocc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rdata     (q_rdata)
	);

	// Count letters, emit occurrence words and the C burst, then clear.
	fmocc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_not_empty),
		.q_rdata    (q_rdata),
		.q_pop      (q_pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.kind       (kind),
		.letter     (letter),
		.position   (position),
		.count      (count),
		.invalid    (invalid),
		.end_of_run (end_of_run)
	);

endmodule

>>> sim/fm_index_occurrence_counter_checker.sv
`timescale 1ns / 100ps

module fm_index_occurrence_counter_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         sym_valid,
	input  logic                         sym_ready,
	input  logic [7:0]                   symbol,
	input  logic                         last,
	input  logic                         res_valid,
	input  logic                         res_ready,
	input  logic                         kind,
	input  logic [fmocc_pkg::CodeW-1:0]  letter,
	input  logic [fmocc_pkg::PosW-1:0]   position,
	input  logic [fmocc_pkg::CountW-1:0] count,
	input  logic                         invalid,
	input  logic                         end_of_run,
	output int                           failures,
	output int                           pending,
	output int                           words_checked
);
	import fmocc_pkg::*;

	typedef enum logic [CodeW-1:0] {
		ALA, CYS, ASP, GLU, PHE, GLY, HIS, ILE, LYS, LEU,
		MET, ASN, PRO, GLN, ARG, SER, THR, VAL, TRP, TYR
	} residue_t;

	localparam logic KindOcc  = 1'b0;
	localparam logic KindCval = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [CodeW-1:0]  letter;
		logic [PosW-1:0]   position;
		logic [CountW-1:0] count;
		logic              invalid;
		logic              end_of_run;
	} result_word_t;

	result_word_t      awaited_words [$];
	logic [CountW-1:0] letter_tally [NumLetters];
	logic [PosW-1:0]   byte_index;
	int                fail_total;
	int                checked_total;

	initial begin
		failures      = 0;
		pending       = 0;
		words_checked = 0;
		fail_total    = 0;
		checked_total = 0;
		byte_index    = '0;
		foreach (letter_tally[i]) letter_tally[i] = '0;
	end

	function automatic logic [CodeW-1:0] residue_code(input logic [7:0] b);
		case (b)
			"A": return ALA;
			"C": return CYS;
			"D": return ASP;
			"E": return GLU;
			"F": return PHE;
			"G": return GLY;
			"H": return HIS;
			"I": return ILE;
			"K": return LYS;
			"L": return LEU;
			"M": return MET;
			"N": return ASN;
			"P": return PRO;
			"Q": return GLN;
			"R": return ARG;
			"S": return SER;
			"T": return THR;
			"V": return VAL;
			"W": return TRP;
			"Y": return TYR;
			"$": return CodeDollar;
			default: return CodeInvalid;
		endcase
	endfunction

	// Occurrence word for the byte, then the C table and a clear on a last byte.
	task automatic predict_words(input logic [7:0] b, input logic is_last);
		logic [CodeW-1:0] code;
		result_word_t     w;
		int               running;
		code         = residue_code(b);
		w.kind       = KindOcc;
		w.letter     = code;
		w.position   = byte_index;
		w.count      = '0;
		w.invalid    = (code == CodeInvalid);
		w.end_of_run = !is_last;
		if (code < NumLetters) begin
			if (letter_tally[code] < CountCap) letter_tally[code]++;
			w.count = letter_tally[code];
		end
		awaited_words.push_back(w);
		if (is_last) begin
			running = 0;
			for (int j = 0; j < NumLetters; j++) begin
				w.kind       = KindCval;
				w.letter     = CodeW'(j);
				w.count      = CountW'(running);
				w.invalid    = 1'b0;
				w.end_of_run = (j == NumLetters - 1);
				awaited_words.push_back(w);
				running += letter_tally[j];
				if (running > CountCap) running = CountCap;
			end
			foreach (letter_tally[i]) letter_tally[i] = '0;
			byte_index = '0;
		end else begin
			byte_index++;
		end
	endtask

	always @(posedge clk) begin
		result_word_t got;
		result_word_t want;
		if (!arst_n) begin
			awaited_words.delete();
			foreach (letter_tally[i]) letter_tally[i] = '0;
			byte_index = '0;
		end else begin
			if (sym_valid && sym_ready) predict_words(symbol, last);
			if (res_valid && res_ready) begin
				got = '{kind, letter, position, count, invalid, end_of_run};
				checked_total++;
				if (awaited_words.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("unexpected word: kind %0d letter %0d pos %0d count %0d inv %0d eor %0d",
							got.kind, got.letter, got.position, got.count, got.invalid,
							got.end_of_run);
				end else begin
					want = awaited_words.pop_front();
					if (got !== want) begin
						fail_total++;
						if (fail_total <= 10) begin
							$display("mismatch: expected kind %0d letter %0d pos %0d count %0d inv %0d eor %0d",
								want.kind, want.letter, want.position, want.count, want.invalid,
								want.end_of_run);
							$display("          got      kind %0d letter %0d pos %0d count %0d inv %0d eor %0d",
								got.kind, got.letter, got.position, got.count, got.invalid,
								got.end_of_run);
						end
					end
				end
			end
		end
		failures      <= fail_total;
		pending       <= awaited_words.size();
		words_checked <= checked_total;
	end

endmodule

>>> sim/fm_index_occurrence_counter_core_test.sv
`timescale 1ns / 100ps

module fm_index_occurrence_counter_core_test;
	import fmocc_pkg::*;

	// Far above the slowest legal run: a few hundred bytes, each with up to
	// 21 result words, under heavy stalls and one long hold-off.
	localparam int CycleLimit = 200_000;
	localparam int HoldCycles = 300;
	localparam int TailCycles = 16;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                sym_valid = 1'b0;
	logic                sym_ready;
	logic [7:0]          symbol    = '0;
	logic                last      = 1'b0;
	logic                res_valid;
	logic                res_ready = 1'b0;
	logic                kind;
	logic [CodeW-1:0]    letter;
	logic [PosW-1:0]     position;
	logic [CountW-1:0]   count;
	logic                invalid;
	logic                end_of_run;

	int failures;
	int pending;
	int words_checked;

	// Sender and receiver pacing: percent of words sent after an idle gap, percent of cycles stalled
	int idle_pct  = 0;
	int stall_pct = 0;

	// Long receiver hold-off: requested here, counted in the receiver process
	logic hold_request = 1'b0;
	logic hold_taken   = 1'b0;
	int   hold_left    = 0;

	int bytes_sent      = 0;
	int transforms_sent = 0;

	always #4 clk = ~clk;

	fm_index_occurrence_counter_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sym_valid  (sym_valid),
		.sym_ready  (sym_ready),
		.symbol     (symbol),
		.last       (last),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.kind       (kind),
		.letter     (letter),
		.position   (position),
		.count      (count),
		.invalid    (invalid),
		.end_of_run (end_of_run)
	);

	fm_index_occurrence_counter_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.sym_valid     (sym_valid),
		.sym_ready     (sym_ready),
		.symbol        (symbol),
		.last          (last),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.kind          (kind),
		.letter        (letter),
		.position      (position),
		.count         (count),
		.invalid       (invalid),
		.end_of_run    (end_of_run),
		.failures      (failures),
		.pending       (pending),
		.words_checked (words_checked)
	);

	// Receiver: honour a pending hold-off first, otherwise stall at random
	always @(posedge clk) begin
		if (hold_request && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left  = HoldCycles;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: give up if the run hangs
	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("simulation failed");
		$finish;
	end

	// Offer one word and hold it until the block takes it. Called just after
	// a rising edge; returns at the edge where the word was accepted.
	task automatic send_word(input logic [7:0] b, input logic is_last);
		int gap;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 4);
			sym_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sym_valid <= 1'b1;
		symbol    <= b;
		last      <= is_last;
		do @(posedge clk); while (!sym_ready);
		bytes_sent++;
	endtask

	// Mostly amino-acid letters, some '$', the rest any byte; any byte at all when noisy
	function automatic logic [7:0] pick_byte(input bit noisy);
		int r;
		r = $urandom_range(99);
		if (noisy || r >= 88) return 8'($urandom_range(255));
		if (r >= 80) return DollarChar;
		return LetterChar[$urandom_range(NumLetters - 1)];
	endfunction

	task automatic send_transform(input int len, input bit noisy);
		for (int i = 0; i < len; i++) send_word(pick_byte(noisy), i == len - 1);
		transforms_sent++;
	endtask

	// Drop valid and wait until every expected word has come back. Wait for the
	// checker first so the count includes the words of the last accepted byte.
	task automatic drain;
		sym_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic run_random(input int n_bytes, input int idle, input int stall, input bit hold);
		int sent;
		int len;
		idle_pct   = idle;
		stall_pct <= stall;
		if (hold) hold_request <= 1'b1;
		sent = 0;
		while (sent < n_bytes) begin
			// Mostly short transforms, now and then a longer one
			len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			send_transform(len, $urandom_range(9) == 0);
			sent += len;
		end
		drain;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every letter, a repeat, '$', both extreme bytes as invalid,
		// a last byte that is invalid, and a transform of a lone '$'
		idle_pct   = 0;
		stall_pct <= 0;
		for (int i = 0; i < NumLetters; i++) send_word(LetterChar[i], 1'b0);
		send_word(LetterChar[0], 1'b0);
		send_word(DollarChar, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b1);
		send_word(DollarChar, 1'b1);
		transforms_sent += 2;
		drain;

		// Random phases: free running, idle sender, stalling receiver with one
		// long hold-off that fills the block, then both at once
		run_random(80, 0, 0, 1'b0);
		run_random(80, 65, 0, 1'b0);
		run_random(80, 0, 65, 1'b1);
		run_random(80, 34, 34, 1'b0);

		// Let any late word show up before the verdict
		repeat (TailCycles) @(posedge clk);

		$display("covered %0d bytes in %0d transforms, %0d result words checked",
			bytes_sent, transforms_sent, words_checked);
		$display("incl. invalid and '$' bytes, C bursts and a long receiver hold-off");
		if (failures == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
